[design/clock_synth_divider_programmer_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the clock synthesizer divider programmer.
// Each macro turns into a concurrent assertion in simulation and into
// nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef CLOCK_SYNTH_DIVIDER_PROGRAMMER_MACROS_SVH
`define CLOCK_SYNTH_DIVIDER_PROGRAMMER_MACROS_SVH
`ifndef SYNTHESIS
`define CSDP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed in the same cycle");
`define CSDP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed in the next cycle");
`else
`define CSDP_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define CSDP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[design/csdp_pkg.sv]
// ----------------------------------------------------------------------------
// csdp_pkg
// Types and constants shared by the divider programmer modules.
// ----------------------------------------------------------------------------
package csdp_pkg;

    localparam int CRYSTAL_W  = 26;
    localparam int DRIVE_W    = 2;
    localparam int FREQ_W     = 32;
    localparam int INDEX_W    = 3;
    localparam int PLL_W      = 31;
    localparam int FRAC_W     = 10;
    localparam int QUOT_W     = PLL_W + FRAC_W;
    localparam int DIV_CNT_W  = 6;
    localparam int STEP_W     = 5;

    localparam logic [4:0]  PLL_MULT       = 5'd19;
    localparam logic [STEP_W-1:0] LAST_STEP = 5'd18;
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 6'd41;
    localparam logic [17:0] P1_OFFSET      = 18'd512;
    localparam logic [7:0]  CTRL_BASE_VAL  = 8'h4C;
    localparam logic [7:0]  PLL_RESET_VAL  = 8'hA0;
    localparam logic [7:0]  ADDR_PLLA      = 8'd26;
    localparam logic [7:0]  ADDR_MS0       = 8'd42;
    localparam logic [7:0]  ADDR_CLK_CTRL0 = 8'd16;
    localparam logic [7:0]  ADDR_PLL_RESET = 8'd177;
    localparam logic [7:0]  ADDR_CLK_OE    = 8'd3;

    localparam logic CFG_CRYSTAL_HZ    = 1'b0;
    localparam logic CFG_DRIVE_STRENGTH = 1'b1;

    typedef struct packed {
        logic [FREQ_W-1:0]  target_hz;
        logic [INDEX_W-1:0] output_index;
    } job_t;

endpackage

[design/csdp_if.sv]
// ----------------------------------------------------------------------------
// csdp_req_if, csdp_wr_if
// Valid/ready channels for requests and for register write transactions.
// ----------------------------------------------------------------------------
interface csdp_req_if
    import csdp_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [FREQ_W-1:0]  target_hz;
    logic [INDEX_W-1:0] output_index;

    modport source (output valid, output target_hz, output output_index, input ready);
    modport sink (input valid, input target_hz, input output_index, output ready);
endinterface

interface csdp_wr_if;
    logic       valid;
    logic       ready;
    logic [7:0] reg_addr;
    logic [7:0] reg_value;
    logic       last_write;

    modport source (output valid, output reg_addr, output reg_value, output last_write,
                    input ready);
    modport sink (input valid, input reg_addr, input reg_value, input last_write,
                  output ready);
endinterface

[design/clock_synth_divider_programmer.sv]
// ----------------------------------------------------------------------------
// clock_synth_divider_programmer
// Turns a frequency request into the 19 register writes for a synthesizer.
// ----------------------------------------------------------------------------
// Each accepted request with a nonzero frequency and a valid output index
// yields 19 write transactions, the last one flagged by last_write; other
// requests are dropped without writes. In the back end a request is taken in the
// idle state, then passes through the bit-serial divider that produces the integer
// and 10-bit fractional divider, then through the emit state that sends the writes
// and stalls while the write channel is not ready. A two-entry queue lets requests arrive meanwhile.
module clock_synth_divider_programmer
    import csdp_pkg::*;
#(
    parameter int NUM_OUTPUTS = 6
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [CRYSTAL_W-1:0] cfg_wdata,
    csdp_req_if.sink             req,
    csdp_wr_if.source            wr
);

    logic [CRYSTAL_W-1:0] crystal_hz_reg;
    logic [DRIVE_W-1:0]   drive_strength_reg;
    logic                 job_valid;
    logic                 job_ready;
    job_t                 job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crystal_hz_reg <= CRYSTAL_W'(25000000);
            drive_strength_reg <= 2'd3;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CRYSTAL_HZ:     crystal_hz_reg <= cfg_wdata;
                CFG_DRIVE_STRENGTH: drive_strength_reg <= cfg_wdata[DRIVE_W-1:0];
                default:            crystal_hz_reg <= crystal_hz_reg;
            endcase
        end
    end

    csdp_front #(
        .NUM_OUTPUTS (NUM_OUTPUTS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .job_valid (job_valid),
        .job       (job),
        .job_ready (job_ready)
    );

    csdp_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .crystal_hz     (crystal_hz_reg),
        .drive_strength (drive_strength_reg),
        .job_valid      (job_valid),
        .job            (job),
        .job_ready      (job_ready),
        .wr             (wr)
    );

endmodule

[design/csdp_front.sv]
// ----------------------------------------------------------------------------
// csdp_front
// Accepts requests, drops those that cause no writes and queues the rest.
// ----------------------------------------------------------------------------
module csdp_front
    import csdp_pkg::*;
#(
    parameter int NUM_OUTPUTS = 6
)
(
    input  logic           clk,
    input  logic           rst_n,
    csdp_req_if.sink       req,
    output logic           job_valid,
    output job_t           job,
    input  logic           job_ready
);

    job_t       fifo_mem [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;
    logic       good;

    assign req.ready = (count_reg != 2'd2);
    assign good = (req.target_hz != '0) &&
                  ({29'd0, req.output_index} < NUM_OUTPUTS);
    assign push = req.valid && req.ready && good;
    assign pop = job_valid && job_ready;
    assign job_valid = (count_reg != 2'd0);
    assign job = fifo_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= '{target_hz: req.target_hz,
                                      output_index: req.output_index};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule

[design/csdp_back.sv]
// ----------------------------------------------------------------------------
// csdp_back
// Divides the PLL frequency by the target one bit per cycle, then emits the
// run of register write transactions through an output register.
// ----------------------------------------------------------------------------
`include "clock_synth_divider_programmer_macros.svh"

module csdp_back
    import csdp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [CRYSTAL_W-1:0] crystal_hz,
    input  logic [DRIVE_W-1:0]   drive_strength,
    input  logic                 job_valid,
    input  job_t                 job,
    output logic                 job_ready,
    csdp_wr_if.source            wr
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t                 state_reg;
    state_t                 state_next;
    logic [DIV_CNT_W-1:0]   cnt_reg;
    logic [DIV_CNT_W-1:0]   cnt_next;
    logic [STEP_W-1:0]      step_reg;
    logic [STEP_W-1:0]      step_next;
    logic [FREQ_W-1:0]      freq_reg;
    logic [INDEX_W-1:0]     idx_reg;
    logic [FREQ_W-1:0]      rem_reg;
    logic [QUOT_W-1:0]      quot_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [7:0]             out_addr_reg;
    logic [7:0]             out_value_reg;
    logic                   out_last_reg;
    logic [FREQ_W:0]        trial;
    logic                   fits;
    logic [PLL_W-1:0]       pll;
    logic                   load;
    logic [7:0]             mult;
    logic [FRAC_W-1:0]      frac;
    logic [17:0]            p1;
    logic [19:0]            p2;
    logic [7:0]             ms_base;
    logic [7:0]             emit_addr;
    logic [7:0]             emit_value;

    assign job_ready = (state_reg == ST_IDLE);
    assign pll = PLL_W'({5'd0, crystal_hz} * {26'd0, PLL_MULT});
    assign trial = {rem_reg, quot_reg[QUOT_W-1]};
    assign fits = (trial >= {1'b0, freq_reg});
    assign load = (state_reg == ST_EMIT) && (!out_valid_reg || wr.ready);

    assign mult = (quot_reg[QUOT_W-1:FRAC_W+8] != '0) ? 8'hFF : quot_reg[FRAC_W+7:FRAC_W];
    assign frac = quot_reg[FRAC_W-1:0];
    assign p1 = {3'd0, mult, 7'd0} + {11'd0, frac[9:3]} - P1_OFFSET;
    assign p2 = {frac[2:0], 10'd0, frac[9:3]};
    assign ms_base = ADDR_MS0 + {2'd0, idx_reg, 3'd0};

    always_comb
    begin
        emit_addr = 8'd0;
        emit_value = 8'd0;
        case (step_reg)
            5'd0:  begin emit_addr = ADDR_PLLA;        emit_value = 8'h00; end
            5'd1:  begin emit_addr = ADDR_PLLA + 8'd1; emit_value = 8'h01; end
            5'd2:  begin emit_addr = ADDR_PLLA + 8'd2; emit_value = 8'h00; end
            5'd3:  begin emit_addr = ADDR_PLLA + 8'd3; emit_value = 8'h07; end
            5'd4:  begin emit_addr = ADDR_PLLA + 8'd4; emit_value = 8'h80; end
            5'd5:  begin emit_addr = ADDR_PLLA + 8'd5; emit_value = 8'h00; end
            5'd6:  begin emit_addr = ADDR_PLLA + 8'd6; emit_value = 8'h00; end
            5'd7:  begin emit_addr = ADDR_PLLA + 8'd7; emit_value = 8'h00; end
            5'd8:  begin emit_addr = ms_base;          emit_value = 8'hFF; end
            5'd9:  begin emit_addr = ms_base + 8'd1;   emit_value = 8'hFF; end
            5'd10: begin emit_addr = ms_base + 8'd2;   emit_value = {6'd0, p1[17:16]}; end
            5'd11: begin emit_addr = ms_base + 8'd3;   emit_value = p1[15:8]; end
            5'd12: begin emit_addr = ms_base + 8'd4;   emit_value = p1[7:0]; end
            5'd13: begin emit_addr = ms_base + 8'd5;   emit_value = {4'hF, p2[19:16]}; end
            5'd14: begin emit_addr = ms_base + 8'd6;   emit_value = p2[15:8]; end
            5'd15: begin emit_addr = ms_base + 8'd7;   emit_value = p2[7:0]; end
            5'd16:
            begin
                emit_addr = ADDR_CLK_CTRL0 + {5'd0, idx_reg};
                emit_value = CTRL_BASE_VAL + {6'd0, drive_strength};
            end
            5'd17: begin emit_addr = ADDR_PLL_RESET;   emit_value = PLL_RESET_VAL; end
            5'd18:
            begin
                emit_addr = ADDR_CLK_OE;
                emit_value = ~(8'd1 << idx_reg);
            end
            default:
            begin
                emit_addr = 8'd0;
                emit_value = 8'd0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        step_next = step_reg;
        out_valid_next = out_valid_reg;
        if (wr.valid && wr.ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = ST_DIV;
                    cnt_next = DIV_STEPS;
                end
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == 6'd1)
                begin
                    state_next = ST_EMIT;
                    step_next = '0;
                end
            end
            ST_EMIT:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    step_next = step_reg + 1'b1;
                    if (step_reg == LAST_STEP)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && job_valid)
        begin
            freq_reg <= job.target_hz;
            idx_reg <= job.output_index;
            rem_reg <= '0;
            quot_reg <= {pll, {FRAC_W{1'b0}}};
        end
        else if (state_reg == ST_DIV)
        begin
            rem_reg <= fits ? FREQ_W'(trial - {1'b0, freq_reg}) : trial[FREQ_W-1:0];
            quot_reg <= {quot_reg[QUOT_W-2:0], fits};
        end
        if (load)
        begin
            out_addr_reg <= emit_addr;
            out_value_reg <= emit_value;
            out_last_reg <= (step_reg == LAST_STEP);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
            step_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            step_reg <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign wr.valid = out_valid_reg;
    assign wr.reg_addr = out_addr_reg;
    assign wr.reg_value = out_value_reg;
    assign wr.last_write = out_last_reg;

    `CSDP_ASSERT_NEXT(a_last_ends_run, clk, rst_n, load && (step_reg == LAST_STEP), (state_reg == ST_IDLE))
    `CSDP_ASSERT_SAME(a_div_count_live, clk, rst_n, (state_reg == ST_DIV), (cnt_reg != '0))
    `CSDP_ASSERT_SAME(a_rem_bound, clk, rst_n, (state_reg == ST_DIV), (rem_reg < freq_reg))

endmodule
